/* rtl/sta_pkg.sv */
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants for the scan code line editor
// Set-1 scan codes, key ROMs, request/result payloads and editor state.
// ----------------------------------------------------------------------------
package sta_pkg;

	// set-1 scan codes
	localparam logic [7:0] SC_CAPS      = 8'h3A;
	localparam logic [7:0] SC_RSHIFT    = 8'h36;
	localparam logic [7:0] SC_LSHIFT    = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
	localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
	localparam logic [7:0] SC_CTRL      = 8'h1D;
	localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
	localparam logic [7:0] SC_BKSP      = 8'h0E;
	localparam logic [7:0] SC_ALT       = 8'h38;
	localparam logic [7:0] SC_ALT_UP    = 8'hB8;
	localparam logic [7:0] SC_F1        = 8'h3B;
	localparam logic [7:0] SC_L         = 8'h26;

	// codes at or above this have no ROM entry
	localparam logic [7:0] ROM_SIZE = 8'd62;

	localparam logic [6:0] ASCII_NL      = 7'h0A;
	localparam logic [6:0] ASCII_LOWER_A = 7'h61;
	localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;

	// request kinds
	localparam logic REQ_SCAN      = 1'b0;
	localparam logic REQ_SET_INDEX = 1'b1;

	// ROMs padded to a full 6-bit index; the last two entries are never used
	localparam logic [6:0] ROM_PLAIN [64] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] ROM_SHIFT [64] = '{
		7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	typedef struct packed {
		logic       req_type;
		logic [7:0] scan_code;
		logic [6:0] new_index;
	} sta_req_t;

	typedef struct packed {
		logic       echo_valid;
		logic [6:0] echo_char;
		logic       write_valid;
		logic [6:0] write_index;
		logic [6:0] write_char;
		logic       erase_valid;
		logic [6:0] erase_index;
		logic       clear_line;
		logic       switch_valid;
		logic [1:0] switch_terminal;
		logic       line_done;
		logic [6:0] line_index;
	} sta_res_t;

	typedef struct packed {
		logic       caps;
		logic       shift;
		logic       ctrl;
		logic       alt;
		logic [6:0] cursor;
		logic       seen;
	} sta_state_t;

endpackage

/* rtl/sta_stream_if.sv */
// ----------------------------------------------------------------------------
// sta_stream_if: valid/ready channel
// One payload per transfer; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface sta_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sta_decode.sv */
// ----------------------------------------------------------------------------
// sta_decode: scan code decode and line edit step
// Maps one request against the current editor state to a result and next state.
// ----------------------------------------------------------------------------
module sta_decode import sta_pkg::*; #(
	parameter int NUM_TERMINALS = 3,
	parameter int LINE_LENGTH   = 128
) (
	input  sta_req_t   req,
	input  sta_state_t st,
	output sta_res_t   res,
	output sta_state_t nxt
);

	localparam logic [6:0] LAST_SLOT = 7'(LINE_LENGTH - 1);
	localparam logic [7:0] KEY_LIMIT = 8'(int'(SC_F1) + NUM_TERMINALS);

	logic [6:0] ch;
	logic [6:0] plain;
	logic [6:0] shifted;
	logic       is_letter;
	logic [7:0] fkey_off;

	assign plain     = ROM_PLAIN[req.scan_code[5:0]];
	assign shifted   = ROM_SHIFT[req.scan_code[5:0]];
	assign is_letter = (plain >= ASCII_LOWER_A) && (plain <= ASCII_LOWER_Z);
	assign fkey_off  = req.scan_code - SC_F1;

	always_comb begin
		nxt = st;
		res = '0;
		ch  = '0;

		if (req.req_type == REQ_SET_INDEX) begin
			nxt.cursor = (req.new_index > LAST_SLOT) ? LAST_SLOT : req.new_index;
			nxt.seen   = 1'b0;
		end else begin
			unique case (req.scan_code) inside
				SC_CAPS:                    nxt.caps  = ~st.caps;
				SC_RSHIFT, SC_LSHIFT:       nxt.shift = 1'b1;
				SC_RSHIFT_UP, SC_LSHIFT_UP: nxt.shift = 1'b0;
				SC_CTRL:                    nxt.ctrl  = 1'b1;
				SC_CTRL_UP:                 nxt.ctrl  = 1'b0;
				SC_ALT:                     nxt.alt   = 1'b1;
				SC_ALT_UP:                  nxt.alt   = 1'b0;
				SC_BKSP: begin
					if (st.cursor != '0) begin
						nxt.cursor      = st.cursor - 7'd1;
						res.erase_valid = 1'b1;
						res.erase_index = st.cursor - 7'd1;
					end
				end
				default: begin
					if (req.scan_code >= KEY_LIMIT || req.scan_code >= ROM_SIZE) begin
						// release codes and unused bytes
					end else if (st.alt) begin
						if (req.scan_code >= SC_F1) begin
							res.switch_valid    = 1'b1;
							res.switch_terminal = fkey_off[1:0];
						end
					end else if (is_letter) begin
						if (st.ctrl && req.scan_code == SC_L) begin
							nxt.cursor     = '0;
							res.clear_line = 1'b1;
						end else begin
							ch = (st.shift ^ st.caps) ? shifted : plain;
						end
					end else begin
						ch = st.shift ? shifted : plain;
					end
				end
			endcase
		end

		// append to the line; the last slot only ever takes a newline
		if (ch != '0) begin
			if (st.cursor >= LAST_SLOT) begin
				if (ch == ASCII_NL || st.seen) begin
					res.echo_valid  = 1'b1;
					res.echo_char   = ch;
					res.write_valid = 1'b1;
					res.write_index = LAST_SLOT;
					res.write_char  = ASCII_NL;
					nxt.seen        = 1'b1;
				end
			end else begin
				res.echo_valid  = 1'b1;
				res.echo_char   = ch;
				res.write_valid = 1'b1;
				res.write_index = st.cursor;
				res.write_char  = ch;
				nxt.cursor      = st.cursor + 7'd1;
				if (ch == ASCII_NL) begin
					nxt.seen = 1'b1;
				end
			end
		end

		res.line_done  = nxt.seen;
		res.line_index = nxt.cursor;
	end

endmodule

/* rtl/scancode_to_ascii_line_editor.sv */
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_editor: set-1 keyboard front end with a line editor
// Turns scan code bytes into echo, line store, erase, clear and switch events.
// ----------------------------------------------------------------------------
// One request in, one result out. A request is either a raw set-1 scan code
// byte or a line index load (which also clears the line-done flag). The block
// sustains one transfer per clock in both directions while the result side is
// ready; a request passes through the input register and then the result
// register before its result is presented. The editor state (modifier flags,
// cursor, newline flag) is updated in the decode stage as a request moves into
// the result register, so back-to-back requests each see the state left by the
// one before. Backpressure on the result side stalls the pipeline; both
// registers fill before the request side drops ready. The line store itself
// lives outside: write_valid/write_index/write_char and erase_valid/
// erase_index drive it, and clear_line asks for the whole store and the screen
// to be wiped.
// ----------------------------------------------------------------------------
module scancode_to_ascii_line_editor import sta_pkg::*; #(
	parameter int NUM_TERMINALS = 3,
	parameter int LINE_LENGTH   = 128
) (
	input logic          clk,
	input logic          arst_n,
	sta_stream_if.sink   req,
	sta_stream_if.source rsp
);

	localparam logic [6:0] LAST_SLOT = 7'(LINE_LENGTH - 1);

	// input stage
	logic       valid_s1;
	sta_req_t   req_s1;
	// result stage
	logic       valid_s2;
	sta_res_t   res_s2;
	// editor state
	sta_state_t state_q;

	sta_res_t   res_d;
	sta_state_t state_d;
	logic       adv_s1;

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || !valid_s2 || rsp.ready;

	sta_decode #(
		.NUM_TERMINALS (NUM_TERMINALS),
		.LINE_LENGTH   (LINE_LENGTH)
	) u_decode (
		.req (req_s1),
		.st  (state_q),
		.res (res_d),
		.nxt (state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_d;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.payload;
		end
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign rsp.valid   = valid_s2;
	assign rsp.payload = res_s2;

	// cursor never leaves the line
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cursor <= LAST_SLOT)
		else $error("cursor beyond last slot");

	// every echo comes with a line store write
	a_echo_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.echo_valid == res_s2.write_valid))
		else $error("echo without store write");

	// one kind of line event per result
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({res_s2.write_valid, res_s2.erase_valid,
			res_s2.clear_line, res_s2.switch_valid}))
		else $error("multiple line events in one result");

	// reported index matches the cursor left behind
	a_index_track: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (res_s2.line_index == state_q.cursor
			&& res_s2.line_done == state_q.seen))
		else $error("result index out of step with cursor");

endmodule
